// ----- hw/rtl/mfel_pkg.sv -----
package mfel_pkg;

    localparam int NUM_PINS       = 24;
    localparam int BYTE_W         = 8;
    localparam int MAX_BYTES      = 3;
    localparam int DEF_WINDOW     = 8;
    localparam int DEF_PORT_BYTES = 3;

    // beat kinds; code 3 means nothing and is ignored
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } t_kind;

    // register within a byte group, taken from the low address bits
    typedef enum logic [1:0] {
        REG_LEVEL  = 2'd0,
        REG_RISE   = 2'd1,
        REG_FALL   = 2'd2,
        REG_CHANGE = 2'd3
    } t_reg_sel;

    typedef struct packed {
        logic [1:0]          kind;
        logic [NUM_PINS-1:0] raw_inputs;
        logic [3:0]          reg_address;
        logic [BYTE_W-1:0]   write_byte;
    } t_in_beat;

    typedef struct packed {
        logic [BYTE_W-1:0]   read_byte;
        logic [NUM_PINS-1:0] pin_drive;
    } t_out_beat;

endpackage

// ----- hw/rtl/mfel_filter.sv -----
module mfel_filter
    import mfel_pkg::*;
#(
    parameter int WINDOW = DEF_WINDOW
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick,
    input  logic [NUM_PINS-1:0] i_raw,
    output logic [NUM_PINS-1:0] o_level,
    output logic [NUM_PINS-1:0] o_next_level
);

    localparam int PTR_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int HALF  = WINDOW / 2;

    logic [NUM_PINS-1:0] r_mem [WINDOW];
    logic [NUM_PINS-1:0] r_old_raw;
    logic [PTR_W-1:0]    r_pos, n_pos;
    logic                r_wrapped, n_wrapped;
    logic [CNT_W-1:0]    r_cnt [NUM_PINS];
    logic [CNT_W-1:0]    n_cnt [NUM_PINS];
    logic [NUM_PINS-1:0] r_level, n_level;
    logic [NUM_PINS-1:0] old_bits;

    // slots not yet written since reset hold zero
    assign old_bits = r_wrapped ? r_old_raw : '0;

    always_comb begin
        n_pos     = r_pos;
        n_wrapped = r_wrapped;
        if (i_tick) begin
            if (r_pos == PTR_W'(WINDOW - 1)) begin
                n_pos     = '0;
                n_wrapped = 1'b1;
            end else begin
                n_pos = r_pos + PTR_W'(1);
            end
        end
    end

    // running ones count per pin: add the new sample, drop the oldest
    always_comb begin
        for (int b = 0; b < NUM_PINS; b++) begin
            n_cnt[b] = r_cnt[b];
            if (i_tick) begin
                n_cnt[b] = r_cnt[b] + CNT_W'(i_raw[b]) - CNT_W'(old_bits[b]);
            end
            n_level[b] = (n_cnt[b] >= CNT_W'(HALF));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick) begin
            r_mem[r_pos] <= i_raw;
        end
        r_old_raw <= r_mem[n_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_wrapped <= 1'b0;
            r_level   <= '0;
            for (int b = 0; b < NUM_PINS; b++) begin
                r_cnt[b] <= '0;
            end
        end else begin
            r_pos     <= n_pos;
            r_wrapped <= n_wrapped;
            r_level   <= n_level;
            for (int b = 0; b < NUM_PINS; b++) begin
                r_cnt[b] <= n_cnt[b];
            end
        end
    end

    assign o_level      = r_level;
    assign o_next_level = n_level;

endmodule

// ----- hw/rtl/majority_filter_edge_latch_io_unit.sv -----
// 24-pin digital I/O with majority-vote input filtering, sticky edge capture
// and byte-wide output latches. Each input beat is a sample tick (raw pins
// pushed into a ring of WINDOW samples; a filtered pin is 1 when at least
// WINDOW/2 of its samples are 1), a register read (address 4*b+r: r=0
// filtered byte b, r=1 rising, r=2 falling, r=3 any-edge; edge reads clear
// the byte; bytes at or above PORT_BYTES and addresses 12..15 read 0) or a
// register write (addresses below PORT_BYTES load an output latch byte).
// Every input beat gives exactly one output beat carrying the read data and
// the output pin levels after that beat. Throughput is one beat per cycle
// with output ready; a beat moves through the input register, then the result
// register, and a full result register does not stop the input register from
// taking a beat as long as the result is drained. The sample ring is a
// WINDOW-entry memory with one write and one registered read port; per-pin
// running counts keep the vote to one add/subtract and compare per cycle. No
// clearing pass is needed after reset: a wrap flag treats the slots not yet
// written as zero until the ring first wraps.
module majority_filter_edge_latch_io_unit
    import mfel_pkg::*;
#(
    parameter int WINDOW     = DEF_WINDOW,
    parameter int PORT_BYTES = DEF_PORT_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    // input stage
    logic     r_in_valid;
    t_in_beat r_in;

    // result stage
    logic      r_out_valid;
    t_out_beat r_out;

    // architectural state
    logic [NUM_PINS-1:0] r_rise, n_rise;
    logic [NUM_PINS-1:0] r_fall, n_fall;
    logic [NUM_PINS-1:0] r_change, n_change;
    logic [BYTE_W-1:0]   r_latch [MAX_BYTES];
    logic [BYTE_W-1:0]   n_latch [MAX_BYTES];

    logic                advance;
    logic                do_tick, do_read, do_write;
    logic [1:0]          sel_byte;
    t_reg_sel            sel_reg;
    logic                byte_ok;
    logic [NUM_PINS-1:0] byte_mask;
    logic [NUM_PINS-1:0] level, n_level, changed;
    logic [BYTE_W-1:0]   rd_byte;
    logic [NUM_PINS-1:0] pins_next;

    // the item in the input register moves on whenever the result slot frees up
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign do_tick  = advance && (r_in.kind == KIND_TICK);
    assign do_read  = advance && (r_in.kind == KIND_READ);
    assign do_write = advance && (r_in.kind == KIND_WRITE);

    assign sel_byte  = r_in.reg_address[3:2];
    assign sel_reg   = t_reg_sel'(r_in.reg_address[1:0]);
    assign byte_ok   = (32'(sel_byte) < PORT_BYTES);
    assign byte_mask = NUM_PINS'({{(NUM_PINS - BYTE_W){1'b0}}, {BYTE_W{1'b1}}})
                       << {sel_byte, 3'b000};

    mfel_filter #(
        .WINDOW (WINDOW)
    ) u_filter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (do_tick),
        .i_raw        (r_in.raw_inputs),
        .o_level      (level),
        .o_next_level (n_level)
    );

    assign changed = do_tick ? (n_level ^ level) : '0;

    // byte b of a 24-bit pin vector, zero for the unused group
    function automatic logic [BYTE_W-1:0] pick_byte(
        input logic [NUM_PINS-1:0] vec,
        input logic [1:0]          b
    );
        logic [BYTE_W-1:0] res;
        case (b)
            2'd0:    res = vec[BYTE_W-1:0];
            2'd1:    res = vec[2*BYTE_W-1:BYTE_W];
            2'd2:    res = vec[3*BYTE_W-1:2*BYTE_W];
            default: res = '0;
        endcase
        return res;
    endfunction

    // read mux
    always_comb begin
        rd_byte = '0;
        if (do_read && byte_ok) begin
            unique case (sel_reg)
                REG_LEVEL:  rd_byte = pick_byte(level, sel_byte);
                REG_RISE:   rd_byte = pick_byte(r_rise, sel_byte);
                REG_FALL:   rd_byte = pick_byte(r_fall, sel_byte);
                REG_CHANGE: rd_byte = pick_byte(r_change, sel_byte);
                default:    rd_byte = '0;
            endcase
        end
    end

    // sticky edges: set by ticks, cleared byte-wise by reads
    always_comb begin
        n_rise   = r_rise   | (changed & n_level);
        n_fall   = r_fall   | (changed & level);
        n_change = r_change | changed;
        if (do_read && byte_ok) begin
            case (sel_reg)
                REG_RISE:   n_rise   = r_rise   & ~byte_mask;
                REG_FALL:   n_fall   = r_fall   & ~byte_mask;
                REG_CHANGE: n_change = r_change & ~byte_mask;
                default:    ;
            endcase
        end
    end

    // output latches; groups at or above PORT_BYTES never load
    always_comb begin
        for (int k = 0; k < MAX_BYTES; k++) begin
            n_latch[k] = r_latch[k];
            if (do_write && (32'(r_in.reg_address) == k) && (k < PORT_BYTES)) begin
                n_latch[k] = r_in.write_byte;
            end
        end
    end

    assign pins_next = {n_latch[2], n_latch[1], n_latch[0]};

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rise      <= '0;
            r_fall      <= '0;
            r_change    <= '0;
            for (int k = 0; k < MAX_BYTES; k++) begin
                r_latch[k] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_rise   <= n_rise;
            r_fall   <= n_fall;
            r_change <= n_change;
            for (int k = 0; k < MAX_BYTES; k++) begin
                r_latch[k] <= n_latch[k];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_beat;
        end
        if (advance) begin
            r_out.read_byte <= rd_byte;
            r_out.pin_drive <= pins_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // ready only drops while a beat is held in the input register
    a_ready_low_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid)
        else $error("input stage stalled while empty");

    // every beat leaving the input register lands in the result register
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result beat lost");

    // filtered levels move only on sample ticks
    a_level_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !do_tick |=> $stable(level))
        else $error("filtered level changed without a tick");

    // a rising filtered pin always leaves its rising and any-edge bits set
    a_rise_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_tick |=> (((r_rise & r_change) & $past(n_level & ~level))
                     == $past(n_level & ~level)))
        else $error("rising edge not captured");

    // a write to byte 0 shows up on the low pins of the same result beat
    a_latch_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_write && (r_in.reg_address == 4'd0))
        |=> (r_out.pin_drive[BYTE_W-1:0] == $past(r_in.write_byte)))
        else $error("output latch write not reflected");

endmodule
